// ----- rtl/cpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_pkg: shared types, constants and helpers of the clutched position clamp
// all positions are signed Q16.8 mm in 24 bits
// ----------------------------------------------------------------------------
package cpc_pkg;

	localparam int unsigned POS_W   = 24;
	localparam int unsigned SCALE_W = 12;
	localparam int unsigned LIMIT_W = 23;
	localparam int unsigned IDX_W   = 3;
	// working width for intermediate sums and rounding
	localparam int unsigned WIDE_W  = 38;
	localparam int unsigned PROD_W  = POS_W + SCALE_W + 1;
	localparam int unsigned FRAC_W  = 8;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [WIDE_W-1:0] wide_t;
	typedef logic [SCALE_W-1:0]       scale_t;
	typedef logic [LIMIT_W-1:0]       limit_t;

	localparam pos_t POS_MAX = pos_t'(24'sh7FFFFF);
	localparam pos_t POS_MIN = pos_t'(24'sh800000);

	localparam scale_t SCALE_RST   = scale_t'(12'd256);
	localparam limit_t LIMIT_X_RST = limit_t'(23'd51200);
	localparam limit_t LIMIT_Y_RST = limit_t'(23'd51200);
	localparam limit_t LIMIT_Z_RST = limit_t'(23'd25600);

	// rounding constant: one half of the Q4.8 scale unit
	localparam wide_t ROUND_HALF = wide_t'(128);

	typedef enum logic [IDX_W-1:0] {
		REG_HOME_X  = 3'd0,
		REG_HOME_Y  = 3'd1,
		REG_HOME_Z  = 3'd2,
		REG_SCALE   = 3'd3,
		REG_LIMIT_X = 3'd4,
		REG_LIMIT_Y = 3'd5,
		REG_LIMIT_Z = 3'd6
	} reg_idx_t;

	// per-beat control from the top level to each axis
	typedef struct packed {
		logic en;
		logic pressed;
		logic hold_ended;
	} axis_ctl_t;

	function automatic pos_t sat24(input wide_t v);
		pos_t r;
		if (v > wide_t'(POS_MAX)) begin
			r = POS_MAX;
		end else if (v < wide_t'(POS_MIN)) begin
			r = POS_MIN;
		end else begin
			r = v[POS_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/cpc_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_scale: home subtract and motion scaling of one axis
// two pipeline stages: product, then round to nearest and saturate
// ----------------------------------------------------------------------------
module cpc_scale (
	input  logic          clk,
	input  logic          load_s2,
	input  logic          load_s3,
	input  cpc_pkg::pos_t raw_s1,
	input  cpc_pkg::pos_t home,
	input  cpc_pkg::scale_t scale,
	output cpc_pkg::pos_t pos_s3
);

	logic signed [cpc_pkg::PROD_W-1:0] prod_c;
	logic signed [cpc_pkg::PROD_W-1:0] prod_s2;
	cpc_pkg::pos_t  diff_c;
	cpc_pkg::wide_t rnd_c;
	cpc_pkg::wide_t shr_c;
	logic signed [cpc_pkg::SCALE_W:0] scale_sgn;

	assign diff_c    = cpc_pkg::sat24(cpc_pkg::wide_t'(raw_s1) - cpc_pkg::wide_t'(home));
	assign scale_sgn = $signed({1'b0, scale});
	assign prod_c    = cpc_pkg::PROD_W'(diff_c) * cpc_pkg::PROD_W'(scale_sgn);

	// ties go toward plus infinity: add one half, then floor
	assign rnd_c = cpc_pkg::wide_t'(prod_s2) + cpc_pkg::ROUND_HALF;
	assign shr_c = rnd_c >>> cpc_pkg::FRAC_W;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			prod_s2 <= prod_c;
		end
		if (load_s3) begin
			pos_s3 <= cpc_pkg::sat24(shr_c);
		end
	end

endmodule

// ----- rtl/cpc_axis.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpc_axis: clip, clamp and clutch state of one axis
// the held output register doubles as the output payload register
// ----------------------------------------------------------------------------
module cpc_axis (
	input  logic               clk,
	input  logic               arst_n,
	input  cpc_pkg::axis_ctl_t ctl,
	input  cpc_pkg::pos_t      pos,
	input  cpc_pkg::limit_t    limit,
	output cpc_pkg::pos_t      held
);

	cpc_pkg::pos_t clip_q;
	cpc_pkg::pos_t clutch_q;
	cpc_pkg::pos_t grab_q;
	cpc_pkg::pos_t disp_q;
	cpc_pkg::pos_t held_q;

	logic signed [cpc_pkg::POS_W:0] lim_pos;
	logic signed [cpc_pkg::POS_W:0] lim_neg;
	cpc_pkg::pos_t cur_c;
	cpc_pkg::pos_t cur_f;
	cpc_pkg::pos_t clip_hi;
	cpc_pkg::pos_t clip_lo;
	logic          over;
	logic          under;

	assign lim_pos = $signed({2'b00, limit});
	assign lim_neg = -lim_pos;

	assign cur_c = cpc_pkg::sat24(cpc_pkg::wide_t'(pos) - cpc_pkg::wide_t'(clip_q)
		- cpc_pkg::wide_t'(clutch_q));
	assign over  = ((cpc_pkg::POS_W+1)'(cur_c) > lim_pos);
	assign under = ((cpc_pkg::POS_W+1)'(cur_c) < lim_neg);

	// clip offset chosen so the clamped value is reached exactly
	assign clip_hi = cpc_pkg::sat24(cpc_pkg::wide_t'(pos) - cpc_pkg::wide_t'(clutch_q)
		- cpc_pkg::wide_t'(lim_pos));
	assign clip_lo = cpc_pkg::sat24(cpc_pkg::wide_t'(pos) - cpc_pkg::wide_t'(clutch_q)
		+ cpc_pkg::wide_t'(lim_pos));

	always_comb begin
		if (over) begin
			cur_f = lim_pos[cpc_pkg::POS_W-1:0];
		end else if (under) begin
			cur_f = lim_neg[cpc_pkg::POS_W-1:0];
		end else begin
			cur_f = cur_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q   <= '0;
			clutch_q <= '0;
			grab_q   <= '0;
			disp_q   <= '0;
			held_q   <= '0;
		end else if (ctl.en) begin
			if (over) begin
				clip_q <= clip_hi;
			end else if (under) begin
				clip_q <= clip_lo;
			end
			if (!ctl.pressed && !ctl.hold_ended) begin
				// first released beat after a hold
				clutch_q <= cpc_pkg::sat24(cpc_pkg::wide_t'(clutch_q)
					+ cpc_pkg::wide_t'(disp_q));
			end else if (!ctl.pressed) begin
				held_q <= cur_f;
				grab_q <= cur_f;
			end
			if (ctl.pressed) begin
				disp_q <= cpc_pkg::sat24(cpc_pkg::wide_t'(cur_f) - cpc_pkg::wide_t'(grab_q));
			end
		end
	end

	assign held = held_q;

endmodule

// ----- rtl/clutched_position_clamp_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clutched_position_clamp_top: three-axis stylus position clamp with clutch
// scales the homed position, clamps each axis and holds output while clutched
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  input    | in_valid, in_stall, raw_x/y/z, clutch_pressed | in
//  output   | out_valid, out_stall, out_x/y/z, holding  | out
//  config   | cfg_we, cfg_index, cfg_data               | in
//
//  one beat per cycle in and out while the output is not stalled; the accepting
//  edge loads the input register, and from there the beat passes through the product,
//  rounding and state/output registers, the last of which drives the output
//  the axis state loop (clip, clamp, clutch) closes within the output register stage
//  reset clears config to defaults, offsets to zero, all valid bits low
//  each stage advances when empty or when the next one moves, so in_stall
//  rises only when every stage holds a beat and the output is stalled
// ----------------------------------------------------------------------------
module clutched_position_clamp_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [cpc_pkg::POS_W-1:0]   raw_x,
	input  logic signed [cpc_pkg::POS_W-1:0]   raw_y,
	input  logic signed [cpc_pkg::POS_W-1:0]   raw_z,
	input  logic                               clutch_pressed,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [cpc_pkg::POS_W-1:0]   out_x,
	output logic signed [cpc_pkg::POS_W-1:0]   out_y,
	output logic signed [cpc_pkg::POS_W-1:0]   out_z,
	output logic                               holding,
	input  logic                               cfg_we,
	input  logic [cpc_pkg::IDX_W-1:0]          cfg_index,
	input  logic [cpc_pkg::POS_W-1:0]          cfg_data
);

	cpc_pkg::pos_t   home_x_q, home_y_q, home_z_q;
	cpc_pkg::scale_t scale_q;
	cpc_pkg::limit_t limit_x_q, limit_y_q, limit_z_q;

	cpc_pkg::pos_t raw_x_s1, raw_y_s1, raw_z_s1;
	logic          pressed_s1, pressed_s2, pressed_s3;
	logic          valid_s1, valid_s2, valid_s3;
	logic          out_valid_q, holding_q, hold_ended_q;

	cpc_pkg::pos_t pos_x_s3, pos_y_s3, pos_z_s3;

	logic out_free, free_s3, free_s2, free_s1;
	logic adv_s1, adv_s2, adv_s3, in_acc;
	cpc_pkg::axis_ctl_t ctl;

	// stage handshake
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s3   = valid_s3 && out_free;
	assign free_s3  = !valid_s3 || out_free;
	assign adv_s2   = valid_s2 && free_s3;
	assign free_s2  = !valid_s2 || free_s3;
	assign adv_s1   = valid_s1 && free_s2;
	assign free_s1  = !valid_s1 || free_s2;
	assign in_stall = !free_s1;
	assign in_acc   = in_valid && free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_x_q  <= '0;
			home_y_q  <= '0;
			home_z_q  <= '0;
			scale_q   <= cpc_pkg::SCALE_RST;
			limit_x_q <= cpc_pkg::LIMIT_X_RST;
			limit_y_q <= cpc_pkg::LIMIT_Y_RST;
			limit_z_q <= cpc_pkg::LIMIT_Z_RST;
		end else if (cfg_we) begin
			unique case (cpc_pkg::reg_idx_t'(cfg_index))
				cpc_pkg::REG_HOME_X:  home_x_q  <= cfg_data;
				cpc_pkg::REG_HOME_Y:  home_y_q  <= cfg_data;
				cpc_pkg::REG_HOME_Z:  home_z_q  <= cfg_data;
				cpc_pkg::REG_SCALE:   scale_q   <= cfg_data[cpc_pkg::SCALE_W-1:0];
				cpc_pkg::REG_LIMIT_X: limit_x_q <= cfg_data[cpc_pkg::LIMIT_W-1:0];
				cpc_pkg::REG_LIMIT_Y: limit_y_q <= cfg_data[cpc_pkg::LIMIT_W-1:0];
				cpc_pkg::REG_LIMIT_Z: limit_z_q <= cfg_data[cpc_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			out_valid_q  <= 1'b0;
			holding_q    <= 1'b0;
			hold_ended_q <= 1'b1;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (adv_s2) begin
				valid_s2 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s3 <= 1'b1;
			end else if (adv_s3) begin
				valid_s3 <= 1'b0;
			end
			out_valid_q <= adv_s3 || (out_valid_q && out_stall);
			if (adv_s3) begin
				holding_q    <= pressed_s3;
				hold_ended_q <= !pressed_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			raw_x_s1   <= raw_x;
			raw_y_s1   <= raw_y;
			raw_z_s1   <= raw_z;
			pressed_s1 <= clutch_pressed;
		end
		if (adv_s1) begin
			pressed_s2 <= pressed_s1;
		end
		if (adv_s2) begin
			pressed_s3 <= pressed_s2;
		end
	end

	cpc_scale u_scale_x (
		.clk     (clk),
		.load_s2 (adv_s1),
		.load_s3 (adv_s2),
		.raw_s1  (raw_x_s1),
		.home    (home_x_q),
		.scale   (scale_q),
		.pos_s3  (pos_x_s3)
	);

	cpc_scale u_scale_y (
		.clk     (clk),
		.load_s2 (adv_s1),
		.load_s3 (adv_s2),
		.raw_s1  (raw_y_s1),
		.home    (home_y_q),
		.scale   (scale_q),
		.pos_s3  (pos_y_s3)
	);

	cpc_scale u_scale_z (
		.clk     (clk),
		.load_s2 (adv_s1),
		.load_s3 (adv_s2),
		.raw_s1  (raw_z_s1),
		.home    (home_z_q),
		.scale   (scale_q),
		.pos_s3  (pos_z_s3)
	);

	assign ctl.en         = adv_s3;
	assign ctl.pressed    = pressed_s3;
	assign ctl.hold_ended = hold_ended_q;

	cpc_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pos    (pos_x_s3),
		.limit  (limit_x_q),
		.held   (out_x)
	);

	cpc_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pos    (pos_y_s3),
		.limit  (limit_y_q),
		.held   (out_y)
	);

	cpc_axis u_axis_z (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.pos    (pos_z_s3),
		.limit  (limit_z_q),
		.held   (out_z)
	);

	assign out_valid = out_valid_q;
	assign holding   = holding_q;

`ifndef SYNTHESIS
	// input backs up only when every stage is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && out_valid_q && out_stall))
		else $error("input stalled with a free pipeline stage");

	// output holds during a clutched beat
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && pressed_s3) |=> ($stable(out_x) && $stable(out_y) && $stable(out_z)))
		else $error("output moved while clutch held");

	// the release beat leaves the output as it is: it folds in the clutch offset and may move the clip offset
	a_release_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && !pressed_s3 && !hold_ended_q)
		|=> ($stable(out_x) && $stable(out_y) && $stable(out_z)))
		else $error("output moved on the release beat");

	// a following beat lands inside the x workspace
	a_x_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && !pressed_s3 && hold_ended_q && $stable(limit_x_q))
		|=> (($signed({out_x[cpc_pkg::POS_W-1], out_x}) <= $signed({2'b00, limit_x_q}))
		&& ($signed({out_x[cpc_pkg::POS_W-1], out_x}) >= -$signed({2'b00, limit_x_q}))))
		else $error("x output outside workspace limit");
`endif

endmodule
